// File: sv/eight_bit_cpu_execute_unit_core_macros.svh
// Assertion macros shared by the execute unit. They assume a clock named clk
// and an active-low reset named arst_n in the module that uses them.
`ifndef EIGHT_BIT_CPU_EXECUTE_UNIT_CORE_MACROS_SVH
`define EIGHT_BIT_CPU_EXECUTE_UNIT_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define EBCEU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define EBCEU_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define EBCEU_ASSERT(label, prop, msg)

`define EBCEU_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: sv/ebceu_pkg.sv
package ebceu_pkg;

	typedef enum logic [5:0] {
		CMD_LDA = 6'd0,
		CMD_LDX = 6'd1,
		CMD_LDY = 6'd2,
		CMD_STA = 6'd3,
		CMD_STX = 6'd4,
		CMD_STY = 6'd5,
		CMD_TAX = 6'd6,
		CMD_TAY = 6'd7,
		CMD_TXA = 6'd8,
		CMD_TYA = 6'd9,
		CMD_TXS = 6'd10,
		CMD_TSX = 6'd11,
		CMD_CLC = 6'd12,
		CMD_SEC = 6'd13,
		CMD_CLD = 6'd14,
		CMD_SED = 6'd15,
		CMD_CLI = 6'd16,
		CMD_SEI = 6'd17,
		CMD_CLV = 6'd18,
		CMD_NOP = 6'd19,
		CMD_AND = 6'd20,
		CMD_ORA = 6'd21,
		CMD_EOR = 6'd22,
		CMD_BIT = 6'd23,
		CMD_INX = 6'd24,
		CMD_INY = 6'd25,
		CMD_DEX = 6'd26,
		CMD_DEY = 6'd27,
		CMD_ADC = 6'd28,
		CMD_SBC = 6'd29,
		CMD_INC = 6'd30,
		CMD_DEC = 6'd31,
		CMD_ASL = 6'd32,
		CMD_LSR = 6'd33,
		CMD_ROL = 6'd34,
		CMD_ROR = 6'd35,
		CMD_CMP = 6'd36,
		CMD_CPX = 6'd37,
		CMD_CPY = 6'd38,
		CMD_BCC = 6'd39,
		CMD_BCS = 6'd40,
		CMD_BEQ = 6'd41,
		CMD_BNE = 6'd42,
		CMD_BPL = 6'd43,
		CMD_BMI = 6'd44,
		CMD_BVC = 6'd45,
		CMD_BVS = 6'd46
	} cmd_t;

	localparam int unsigned FL_C = 0;
	localparam int unsigned FL_Z = 1;
	localparam int unsigned FL_I = 2;
	localparam int unsigned FL_D = 3;
	localparam int unsigned FL_V = 6;
	localparam int unsigned FL_N = 7;

	localparam logic [7:0] ACC_RESET = 8'h00;
	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] FLAGS_RESET = 8'h24;

	typedef struct packed {
		logic [7:0] status;
		logic [7:0] index_y;
		logic [7:0] index_x;
		logic [7:0] accumulator;
		logic page_crossed;
		logic branch_taken;
		logic [15:0] new_pc;
		logic [7:0] write_data;
		logic [15:0] write_address;
	} result_t;

endpackage

// File: sv/eight_bit_cpu_execute_unit_core.sv
// Execute stage of an 8-bit accumulator CPU. It takes one instruction per
// cycle on the input stream and returns one result per instruction, in order,
// passing each through the input register and then the result register. The
// A, X, Y, stack pointer and status registers are updated as an instruction
// moves from the input register to the result register, so the next
// instruction already sees them. Arithmetic is binary only; the D flag is
// stored but has no effect. A stalled output holds the result register and,
// once the input register is also full, stalls the input.
`include "eight_bit_cpu_execute_unit_core_macros.svh"

module eight_bit_cpu_execute_unit_core
	import ebceu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[5:0], operand[13:6], address[29:14], next_pc[45:30],
	// rel_offset[53:46], zero fill[55:54]
	input  logic [55:0] s_tdata,
	// to_memory[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// write_address[15:0], write_data[23:16], new_pc[39:24], branch_taken[40],
	// page_crossed[41], accumulator[49:42], index_x[57:50], index_y[65:58],
	// status[73:66], zero fill[79:74]
	output logic [79:0] m_tdata,
	// write_enable[0]
	output logic        m_tuser
);

	logic valid_s1;
	logic [5:0] cmd_s1;
	logic [7:0] operand_s1;
	logic [15:0] address_s1;
	logic to_memory_s1;
	logic [15:0] next_pc_s1;
	logic [7:0] rel_s1;

	logic [7:0] acc_q;
	logic [7:0] x_q;
	logic [7:0] y_q;
	logic [7:0] sp_q;
	logic [7:0] flags_q;

	logic valid_q;
	logic we_q;
	result_t res_q;

	logic advance;

	logic [7:0] acc_d;
	logic [7:0] x_d;
	logic [7:0] y_d;
	logic [7:0] sp_d;
	logic [7:0] flags_d;
	logic we_d;
	logic [7:0] wdata_d;
	logic [15:0] npc_d;
	logic taken_d;
	logic crossed_d;

	logic [7:0] add_m;
	logic [8:0] sum;
	logic [7:0] sum_res;
	logic [7:0] cmp_reg;
	logic [8:0] diff;
	logic [7:0] sh_in;
	logic [7:0] sh_out;
	logic sh_carry;
	logic [15:0] target;
	logic cond;

	assign advance = valid_s1 && (!valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tdata[5:0];
			operand_s1 <= s_tdata[13:6];
			address_s1 <= s_tdata[29:14];
			next_pc_s1 <= s_tdata[45:30];
			rel_s1 <= s_tdata[53:46];
			to_memory_s1 <= s_tuser;
		end
	end

	always_comb begin
		add_m = (cmd_s1 == CMD_SBC) ? ~operand_s1 : operand_s1;
		sum = {1'b0, acc_q} + {1'b0, add_m} + {8'd0, flags_q[FL_C]};
		sum_res = sum[7:0];

		cmp_reg = (cmd_s1 == CMD_CPX) ? x_q : ((cmd_s1 == CMD_CPY) ? y_q : acc_q);
		diff = {1'b0, cmp_reg} - {1'b0, operand_s1};

		sh_in = to_memory_s1 ? operand_s1 : acc_q;
		if (cmd_s1 == CMD_ASL || cmd_s1 == CMD_ROL) begin
			sh_carry = sh_in[7];
			sh_out = {sh_in[6:0], (cmd_s1 == CMD_ROL) ? flags_q[FL_C] : 1'b0};
		end else begin
			sh_carry = sh_in[0];
			sh_out = {(cmd_s1 == CMD_ROR) ? flags_q[FL_C] : 1'b0, sh_in[7:1]};
		end

		target = next_pc_s1 + {{8{rel_s1[7]}}, rel_s1};
		unique case (cmd_s1) inside
			CMD_BCC: cond = !flags_q[FL_C];
			CMD_BCS: cond = flags_q[FL_C];
			CMD_BEQ: cond = flags_q[FL_Z];
			CMD_BNE: cond = !flags_q[FL_Z];
			CMD_BPL: cond = !flags_q[FL_N];
			CMD_BMI: cond = flags_q[FL_N];
			CMD_BVC: cond = !flags_q[FL_V];
			CMD_BVS: cond = flags_q[FL_V];
			default: cond = 1'b0;
		endcase
	end

	always_comb begin
		acc_d = acc_q;
		x_d = x_q;
		y_d = y_q;
		sp_d = sp_q;
		flags_d = flags_q;
		we_d = 1'b0;
		wdata_d = 8'd0;
		npc_d = next_pc_s1;
		taken_d = 1'b0;
		crossed_d = 1'b0;
		unique case (cmd_s1) inside
			CMD_LDA: acc_d = operand_s1;
			CMD_LDX: x_d = operand_s1;
			CMD_LDY: y_d = operand_s1;
			CMD_STA: begin
				we_d = 1'b1;
				wdata_d = acc_q;
			end
			CMD_STX: begin
				we_d = 1'b1;
				wdata_d = x_q;
			end
			CMD_STY: begin
				we_d = 1'b1;
				wdata_d = y_q;
			end
			CMD_TAX: x_d = acc_q;
			CMD_TAY: y_d = acc_q;
			CMD_TXA: acc_d = x_q;
			CMD_TYA: acc_d = y_q;
			CMD_TXS: sp_d = x_q;
			CMD_TSX: x_d = sp_q;
			CMD_CLC: flags_d[FL_C] = 1'b0;
			CMD_SEC: flags_d[FL_C] = 1'b1;
			CMD_CLD: flags_d[FL_D] = 1'b0;
			CMD_SED: flags_d[FL_D] = 1'b1;
			CMD_CLI: flags_d[FL_I] = 1'b0;
			CMD_SEI: flags_d[FL_I] = 1'b1;
			CMD_CLV: flags_d[FL_V] = 1'b0;
			CMD_AND: acc_d = acc_q & operand_s1;
			CMD_ORA: acc_d = acc_q | operand_s1;
			CMD_EOR: acc_d = acc_q ^ operand_s1;
			CMD_BIT: begin
				flags_d[FL_Z] = (acc_q & operand_s1) == 8'd0;
				flags_d[FL_N] = operand_s1[7];
				flags_d[FL_V] = operand_s1[6];
			end
			CMD_INX: x_d = x_q + 8'd1;
			CMD_INY: y_d = y_q + 8'd1;
			CMD_DEX: x_d = x_q - 8'd1;
			CMD_DEY: y_d = y_q - 8'd1;
			CMD_ADC, CMD_SBC: begin
				acc_d = sum_res;
				flags_d[FL_C] = sum[8];
				flags_d[FL_V] = ((sum_res[7] ^ acc_q[7]) & (sum_res[7] ^ add_m[7]));
			end
			CMD_INC: begin
				we_d = 1'b1;
				wdata_d = operand_s1 + 8'd1;
			end
			CMD_DEC: begin
				we_d = 1'b1;
				wdata_d = operand_s1 - 8'd1;
			end
			CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
				flags_d[FL_C] = sh_carry;
				flags_d[FL_Z] = sh_out == 8'd0;
				flags_d[FL_N] = sh_out[7];
				if (to_memory_s1) begin
					we_d = 1'b1;
					wdata_d = sh_out;
				end else begin
					acc_d = sh_out;
				end
			end
			CMD_CMP, CMD_CPX, CMD_CPY: begin
				flags_d[FL_C] = !diff[8];
				flags_d[FL_Z] = diff[7:0] == 8'd0;
				flags_d[FL_N] = diff[7];
			end
			[CMD_BCC:CMD_BVS]: begin
				if (cond) begin
					npc_d = target;
					taken_d = 1'b1;
					crossed_d = target[15:8] != next_pc_s1[15:8];
				end
			end
			default: begin
			end
		endcase

		unique case (cmd_s1) inside
			CMD_LDA, CMD_TXA, CMD_TYA, CMD_AND, CMD_ORA, CMD_EOR: begin
				flags_d[FL_Z] = acc_d == 8'd0;
				flags_d[FL_N] = acc_d[7];
			end
			CMD_LDX, CMD_TAX, CMD_TSX, CMD_INX, CMD_DEX: begin
				flags_d[FL_Z] = x_d == 8'd0;
				flags_d[FL_N] = x_d[7];
			end
			CMD_LDY, CMD_TAY, CMD_INY, CMD_DEY: begin
				flags_d[FL_Z] = y_d == 8'd0;
				flags_d[FL_N] = y_d[7];
			end
			CMD_ADC, CMD_SBC: begin
				flags_d[FL_Z] = sum_res == 8'd0;
				flags_d[FL_N] = sum_res[7];
			end
			CMD_INC, CMD_DEC: begin
				flags_d[FL_Z] = wdata_d == 8'd0;
				flags_d[FL_N] = wdata_d[7];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= ACC_RESET;
			x_q <= ACC_RESET;
			y_q <= ACC_RESET;
			sp_q <= SP_RESET;
			flags_q <= FLAGS_RESET;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				acc_q <= acc_d;
				x_q <= x_d;
				y_q <= y_d;
				sp_q <= sp_d;
				flags_q <= flags_d;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			we_q <= we_d;
			res_q.write_address <= we_d ? address_s1 : 16'd0;
			res_q.write_data <= wdata_d;
			res_q.new_pc <= npc_d;
			res_q.branch_taken <= taken_d;
			res_q.page_crossed <= crossed_d;
			res_q.accumulator <= acc_d;
			res_q.index_x <= x_d;
			res_q.index_y <= y_d;
			res_q.status <= flags_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser = we_q;
	assign m_tdata = {6'd0, res_q};

	`EBCEU_ASSERT(a_accept_fills_s1, s_tvalid && s_tready |=> valid_s1, "Accepted transfer did not reach the input register.")
	`EBCEU_ASSERT(a_advance_fills_out, advance |=> m_tvalid, "Executed instruction did not reach the result register.")
	`EBCEU_ASSERT(a_no_write_is_zero, m_tvalid && !m_tuser |-> m_tdata[23:0] == 24'd0, "Write address or data nonzero without a write.")
	`EBCEU_ASSERT(a_cross_needs_taken, m_tvalid && m_tdata[41] |-> m_tdata[40], "Page cross flagged on a branch that was not taken.")
	`EBCEU_ASSERT(a_status_fixed_bits, flags_q[5] && !flags_q[4], "Unused or break status bit changed.")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench
	import ebceu_pkg::*;
;

	typedef struct {
		logic [5:0]  command;
		logic [7:0]  operand;
		logic [15:0] address;
		logic        to_memory;
		logic [15:0] next_pc;
		logic [7:0]  rel_offset;
	} instr_t;

	typedef struct {
		logic    write_enable;
		result_t fields;
	} exec_outcome_t;

	// Shadow copy of the register file; it predicts the outcome of each instruction.
	class cpu_shadow;
		logic [7:0] acc;
		logic [7:0] xr;
		logic [7:0] yr;
		logic [7:0] sp;
		logic [7:0] p;
		exec_outcome_t pending_results[$];
		int mismatches;
		int results_seen;

		function new();
			acc = ACC_RESET;
			xr = 8'h00;
			yr = 8'h00;
			sp = SP_RESET;
			p = FLAGS_RESET;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function logic [7:0] nz(logic [7:0] v);
			p[FL_Z] = (v == 8'h00);
			p[FL_N] = v[7];
			return v;
		endfunction

		function void add_with_carry(logic [7:0] m);
			logic [8:0] sum;
			logic [7:0] res;
			sum = {1'b0, acc} + {1'b0, m} + {8'h00, p[FL_C]};
			res = sum[7:0];
			p[FL_V] = (res[7] ^ acc[7]) & (res[7] ^ m[7]);
			p[FL_C] = sum[8];
			acc = nz(res);
		endfunction

		function void compare_reg(logic [7:0] r, logic [7:0] m);
			p[FL_C] = (r >= m);
			void'(nz(r - m));
		endfunction

		function void note_instruction(instr_t it);
			exec_outcome_t o;
			logic [7:0] v;
			logic cin;
			logic cond;
			logic [15:0] target;
			o.write_enable = 1'b0;
			o.fields = '0;
			o.fields.new_pc = it.next_pc;
			cond = 1'b0;
			case (it.command)
				CMD_LDA: acc = nz(it.operand);
				CMD_LDX: xr = nz(it.operand);
				CMD_LDY: yr = nz(it.operand);
				CMD_STA: begin
					o.write_enable = 1'b1;
					o.fields.write_data = acc;
				end
				CMD_STX: begin
					o.write_enable = 1'b1;
					o.fields.write_data = xr;
				end
				CMD_STY: begin
					o.write_enable = 1'b1;
					o.fields.write_data = yr;
				end
				CMD_TAX: xr = nz(acc);
				CMD_TAY: yr = nz(acc);
				CMD_TXA: acc = nz(xr);
				CMD_TYA: acc = nz(yr);
				CMD_TXS: sp = xr;
				CMD_TSX: xr = nz(sp);
				CMD_CLC: p[FL_C] = 1'b0;
				CMD_SEC: p[FL_C] = 1'b1;
				CMD_CLD: p[FL_D] = 1'b0;
				CMD_SED: p[FL_D] = 1'b1;
				CMD_CLI: p[FL_I] = 1'b0;
				CMD_SEI: p[FL_I] = 1'b1;
				CMD_CLV: p[FL_V] = 1'b0;
				CMD_AND: acc = nz(acc & it.operand);
				CMD_ORA: acc = nz(acc | it.operand);
				CMD_EOR: acc = nz(acc ^ it.operand);
				CMD_BIT: begin
					p[FL_Z] = ((acc & it.operand) == 8'h00);
					p[FL_N] = it.operand[7];
					p[FL_V] = it.operand[6];
				end
				CMD_INX: xr = nz(xr + 8'h01);
				CMD_INY: yr = nz(yr + 8'h01);
				CMD_DEX: xr = nz(xr - 8'h01);
				CMD_DEY: yr = nz(yr - 8'h01);
				CMD_ADC: add_with_carry(it.operand);
				CMD_SBC: add_with_carry(~it.operand);
				CMD_INC: begin
					o.write_enable = 1'b1;
					o.fields.write_data = nz(it.operand + 8'h01);
				end
				CMD_DEC: begin
					o.write_enable = 1'b1;
					o.fields.write_data = nz(it.operand - 8'h01);
				end
				CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
					v = it.to_memory ? it.operand : acc;
					cin = p[FL_C];
					if (it.command == CMD_ASL || it.command == CMD_ROL) begin
						p[FL_C] = v[7];
						v = {v[6:0], (it.command == CMD_ROL) ? cin : 1'b0};
					end else begin
						p[FL_C] = v[0];
						v = {(it.command == CMD_ROR) ? cin : 1'b0, v[7:1]};
					end
					void'(nz(v));
					if (it.to_memory) begin
						o.write_enable = 1'b1;
						o.fields.write_data = v;
					end else begin
						acc = v;
					end
				end
				CMD_CMP: compare_reg(acc, it.operand);
				CMD_CPX: compare_reg(xr, it.operand);
				CMD_CPY: compare_reg(yr, it.operand);
				CMD_BCC: cond = !p[FL_C];
				CMD_BCS: cond = p[FL_C];
				CMD_BEQ: cond = p[FL_Z];
				CMD_BNE: cond = !p[FL_Z];
				CMD_BPL: cond = !p[FL_N];
				CMD_BMI: cond = p[FL_N];
				CMD_BVC: cond = !p[FL_V];
				CMD_BVS: cond = p[FL_V];
				default: ;
			endcase
			if (cond) begin
				target = it.next_pc + {{8{it.rel_offset[7]}}, it.rel_offset};
				o.fields.new_pc = target;
				o.fields.branch_taken = 1'b1;
				o.fields.page_crossed = (target[15:8] != it.next_pc[15:8]);
			end
			if (o.write_enable)
				o.fields.write_address = it.address;
			o.fields.accumulator = acc;
			o.fields.index_x = xr;
			o.fields.index_y = yr;
			o.fields.status = p;
			pending_results.push_back(o);
		endfunction

		task report(string what);
			if (mismatches < 40)
				$display("result %0d: %s", results_seen, what);
			mismatches++;
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("%s is %h, expected %h", name, got, want));
		endtask

		task check_result(logic we, result_t got);
			exec_outcome_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				report("result with no instruction outstanding");
				return;
			end
			want = pending_results.pop_front();
			compare_field("write_enable", 16'(we), 16'(want.write_enable));
			compare_field("write_address", got.write_address, want.fields.write_address);
			compare_field("write_data", 16'(got.write_data), 16'(want.fields.write_data));
			compare_field("new_pc", got.new_pc, want.fields.new_pc);
			compare_field("branch_taken", 16'(got.branch_taken),
				16'(want.fields.branch_taken));
			compare_field("page_crossed", 16'(got.page_crossed),
				16'(want.fields.page_crossed));
			compare_field("accumulator", 16'(got.accumulator), 16'(want.fields.accumulator));
			compare_field("index_x", 16'(got.index_x), 16'(want.fields.index_x));
			compare_field("index_y", 16'(got.index_y), 16'(want.fields.index_y));
			compare_field("status", 16'(got.status), 16'(want.fields.status));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tuser;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	cpu_shadow shadow = new();

	eight_bit_cpu_execute_unit_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	function instr_t make_instr(logic [5:0] command, logic [7:0] operand, logic [15:0] address,
			logic to_memory, logic [15:0] next_pc, logic [7:0] rel_offset);
		instr_t it;
		it.command = command;
		it.operand = operand;
		it.address = address;
		it.to_memory = to_memory;
		it.next_pc = next_pc;
		it.rel_offset = rel_offset;
		return it;
	endfunction

	function instr_t random_instr();
		instr_t it;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			it.command = 6'($urandom_range(CMD_BVS + 1, 6'h3F));
		else if (pick < 30)
			it.command = 6'($urandom_range(CMD_BCC, CMD_BVS));
		else
			it.command = 6'($urandom_range(CMD_LDA, CMD_BVS));
		case ($urandom_range(0, 7))
			0: it.operand = 8'h00;
			1: it.operand = 8'hFF;
			2: it.operand = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
			default: it.operand = 8'($urandom);
		endcase
		it.address = 16'($urandom);
		it.to_memory = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0)
			it.next_pc = {8'($urandom), $urandom_range(0, 1) ? 8'($urandom_range(0, 7))
				: 8'($urandom_range(8'hF8, 8'hFF))};
		else
			it.next_pc = 16'($urandom);
		it.rel_offset = 8'($urandom);
		return it;
	endfunction

	task send_instr(instr_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, it.rel_offset, it.next_pc, it.address, it.operand, it.command};
		s_tuser <= it.to_memory;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		shadow.note_instruction(it);
	endtask

	task run_random(int count, int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count)
			send_instr(random_instr());
	endtask

	initial begin
		do
			@(posedge clk);
		while (!arst_n);
		forever begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			@(posedge clk);
			if (m_tvalid && m_tready)
				shadow.check_result(m_tuser, result_t'(m_tdata[73:0]));
		end
	end

	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_instr(make_instr(CMD_TSX, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00));
		send_instr(make_instr(CMD_LDX, 8'h00, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF));
		send_instr(make_instr(CMD_TXS, 8'hFF, 16'h0000, 1'b0, 16'h1234, 8'h00));
		send_instr(make_instr(CMD_LDX, 8'hFF, 16'h0000, 1'b0, 16'h1234, 8'h00));
		send_instr(make_instr(CMD_TSX, 8'h00, 16'h0000, 1'b0, 16'h1234, 8'h00));
		send_instr(make_instr(CMD_LDA, 8'h80, 16'h0000, 1'b0, 16'h0200, 8'h00));
		send_instr(make_instr(CMD_ASL, 8'h00, 16'h0000, 1'b0, 16'h0201, 8'h00));
		send_instr(make_instr(CMD_SEC, 8'h00, 16'h0000, 1'b0, 16'h0202, 8'h00));
		send_instr(make_instr(CMD_SBC, 8'h01, 16'h0000, 1'b0, 16'h0203, 8'h00));
		send_instr(make_instr(CMD_LDA, 8'h7F, 16'h0000, 1'b0, 16'h0204, 8'h00));
		send_instr(make_instr(CMD_ADC, 8'h01, 16'h0000, 1'b0, 16'h0205, 8'h00));
		send_instr(make_instr(CMD_CMP, 8'h80, 16'h0000, 1'b0, 16'h0206, 8'h00));
		send_instr(make_instr(CMD_CMP, 8'hFF, 16'h0000, 1'b0, 16'h0207, 8'h00));
		send_instr(make_instr(CMD_CPX, 8'h00, 16'h0000, 1'b0, 16'h0208, 8'h00));
		send_instr(make_instr(CMD_INC, 8'hFF, 16'hFFFF, 1'b0, 16'h0209, 8'h00));
		send_instr(make_instr(CMD_DEC, 8'h00, 16'h0000, 1'b0, 16'h020A, 8'h00));
		send_instr(make_instr(CMD_ROR, 8'h01, 16'hA55A, 1'b1, 16'h020B, 8'h00));
		send_instr(make_instr(CMD_ROL, 8'hFF, 16'h5AA5, 1'b0, 16'h020C, 8'h00));
		send_instr(make_instr(CMD_LSR, 8'hFF, 16'hFFFF, 1'b0, 16'h020D, 8'h00));
		send_instr(make_instr(CMD_BIT, 8'hC0, 16'h0000, 1'b0, 16'h020E, 8'h00));
		send_instr(make_instr(CMD_BVS, 8'h00, 16'h0000, 1'b0, 16'hFFF0, 8'h7F));
		send_instr(make_instr(CMD_BVC, 8'h00, 16'h0000, 1'b0, 16'h4000, 8'h7F));
		send_instr(make_instr(CMD_BMI, 8'h00, 16'h0000, 1'b0, 16'h0010, 8'h80));
		send_instr(make_instr(6'h3F, 8'hFF, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF));
		send_instr(make_instr(CMD_STA, 8'h00, 16'hFFFF, 1'b0, 16'h8000, 8'h00));

		run_random(560, 32, 84);
		run_random(560, 84, 32);
		run_random(560, 0, 0);
		s_tvalid <= 1'b0;

		while (shadow.pending_results.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (shadow.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/ebceu_pkg.sv
sv/eight_bit_cpu_execute_unit_core.sv
sim/testbench.sv
